// ----- src/bir_pkg.sv -----
// Shared types and constants of the bilinear image rescaler.
package bir_pkg;

  // Field widths fixed by the channel definitions.
  localparam int COORD_W  = 9;
  localparam int DIM_W    = 10;
  localparam int FRAC_W   = 8;
  localparam int POS_W    = DIM_W + FRAC_W;
  localparam int PROD_W   = COORD_W + DIM_W;
  localparam int RECIP_N  = PROD_W + FRAC_W;
  localparam int RECIP_W  = RECIP_N + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  // Queue depths between the parts.
  localparam int CMD_DEPTH = 4;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_LVL_W  = $clog2(OQ_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VFLIP        = 2'd3;

  typedef enum logic {
    KIND_STORE   = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  // One pixel, channel 0 in the low byte.
  typedef logic [2:0][7:0] pix_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [7:0]         sample_c0;
    logic [7:0]         sample_c1;
    logic [7:0]         sample_c2;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_c0;
    logic [15:0] out_c1;
    logic [15:0] out_c2;
  } out_word_t;

  // Command from the front to the back: a store or four neighbour reads.
  typedef struct packed {
    kind_t             kind;
    logic [DIM_W-1:0]  x0;
    logic [DIM_W-1:0]  x1;
    logic [DIM_W-1:0]  y0;
    logic [DIM_W-1:0]  y1;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    pix_t              pix;
  } cmd_t;

endpackage

// ----- src/bir_fifo.sv -----
// Small register queue with occupancy count.
module bir_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] cnt_r;
  logic          wr_en, rd_en;

  assign full  = (cnt_r == LW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign level = cnt_r;
  assign dout  = store_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/bir_front.sv -----
// Front part: accepts words, drops out-of-range ones and maps requests to source positions.
module bir_front
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_WIDTH  = 256,
  parameter int OUT_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  in_word_t         in_word,
  output logic             full,
  input  logic [DIM_W-1:0] src_width,
  input  logic [DIM_W-1:0] src_height,
  input  logic             vflip,
  output logic             cmd_push,
  output cmd_t             cmd_word,
  input  logic             cmd_full
);
  // Saturation limits for the size registers.
  localparam logic [DIM_W-1:0] MAXW_C = (MAX_WIDTH > 1023) ? 10'd1023 : 10'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH_C = (MAX_HEIGHT > 1023) ? 10'd1023 : 10'(MAX_HEIGHT);

  // Reciprocals for the divisions by the output grid size.
  localparam int XL = $clog2(OUT_WIDTH);
  localparam int YL = $clog2(OUT_HEIGHT);
  localparam int XS = RECIP_N + XL;
  localparam int YS = RECIP_N + YL;
  localparam logic [RECIP_W-1:0] XM =
    RECIP_W'((64'd1 << XS) / 64'(OUT_WIDTH) + 64'd1);
  localparam logic [RECIP_W-1:0] YM =
    RECIP_W'((64'd1 << YS) / 64'(OUT_HEIGHT) + 64'd1);
  localparam int MW = PROD_W + RECIP_W;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             keep, accept;
  logic             go1, go2, go3, free1, free2, free3;

  logic               s1_v_r, s2_v_r, s3_v_r;
  kind_t              s1_kind_r, s2_kind_r, s3_kind_r;
  logic [COORD_W-1:0] s1_cx_r, s1_cy_r, s2_cx_r, s2_cy_r, s3_cx_r, s3_cy_r;
  pix_t               s1_pix_r, s2_pix_r, s3_pix_r;
  logic [PROD_W-1:0]  s2_px_r, s2_py_r;
  logic [POS_W-1:0]   s3_xp_r, s3_yp_r;

  logic [PROD_W-1:0] px_nxt, py_nxt;
  logic [MW-1:0]     mx, my;
  logic [POS_W-1:0]  yf, xmax, ymax, xc, yc;
  logic [DIM_W-1:0]  x0, y0;

  // Effective image size: zero reads as one, large values saturate.
  always_comb begin
    if (src_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (src_width > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = src_width;
    end
    if (src_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (src_height > MAXH_C) begin
      h_eff = MAXH_C;
    end else begin
      h_eff = src_height;
    end
  end

  // Classification: stores must hit the memory, requests the output grid.
  always_comb begin
    if (in_word.kind == KIND_REQUEST) begin
      keep = (32'(in_word.coord_x) < OUT_WIDTH) && (32'(in_word.coord_y) < OUT_HEIGHT);
    end else begin
      keep = (32'(in_word.coord_x) < MAX_WIDTH) && (32'(in_word.coord_y) < MAX_HEIGHT);
    end
  end

  // Stall chain of the three stages.
  assign go3    = s3_v_r && !cmd_full;
  assign free3  = !s3_v_r || go3;
  assign go2    = s2_v_r && free3;
  assign free2  = !s2_v_r || go2;
  assign go1    = s1_v_r && free2;
  assign free1  = !s1_v_r || go1;
  assign full   = !free1;
  assign accept = push && free1;

  // Products of output coordinate and image size.
  assign px_nxt = {10'b0, s1_cx_r} * {9'b0, w_eff};
  assign py_nxt = {10'b0, s1_cy_r} * {9'b0, h_eff};

  // Scaling by 256 and division by the grid size through the reciprocal.
  assign mx = MW'(s2_px_r) * MW'(XM);
  assign my = MW'(s2_py_r) * MW'(YM);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= keep;
      end else if (go1) begin
        s1_v_r <= 1'b0;
      end
      if (free2) begin
        s2_v_r <= s1_v_r;
      end
      if (free3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_word.kind;
      s1_cx_r   <= in_word.coord_x;
      s1_cy_r   <= in_word.coord_y;
      s1_pix_r  <= {in_word.sample_c2, in_word.sample_c1, in_word.sample_c0};
    end
    if (free2) begin
      s2_kind_r <= s1_kind_r;
      s2_cx_r   <= s1_cx_r;
      s2_cy_r   <= s1_cy_r;
      s2_pix_r  <= s1_pix_r;
      s2_px_r   <= px_nxt;
      s2_py_r   <= py_nxt;
    end
    if (free3) begin
      s3_kind_r <= s2_kind_r;
      s3_cx_r   <= s2_cx_r;
      s3_cy_r   <= s2_cy_r;
      s3_pix_r  <= s2_pix_r;
      s3_xp_r   <= mx[XS-FRAC_W +: POS_W];
      s3_yp_r   <= my[YS-FRAC_W +: POS_W];
    end
  end

  // Mirror, clamp to the last row or column, and pick the neighbours.
  always_comb begin
    xmax = {w_eff - 1'b1, 8'b0};
    ymax = {h_eff - 1'b1, 8'b0};
    yf   = vflip ? ({h_eff, 8'b0} - s3_yp_r) : s3_yp_r;
    xc   = (s3_xp_r > xmax) ? xmax : s3_xp_r;
    yc   = (yf > ymax) ? ymax : yf;
    x0   = xc[POS_W-1:FRAC_W];
    y0   = yc[POS_W-1:FRAC_W];

    cmd_word.kind = s3_kind_r;
    cmd_word.pix  = s3_pix_r;
    if (s3_kind_r == KIND_REQUEST) begin
      cmd_word.x0 = x0;
      cmd_word.y0 = y0;
      cmd_word.x1 = (({1'b0, x0} + 1'b1) < {1'b0, w_eff}) ? x0 + 1'b1 : x0;
      cmd_word.y1 = (({1'b0, y0} + 1'b1) < {1'b0, h_eff}) ? y0 + 1'b1 : y0;
      cmd_word.fx = xc[FRAC_W-1:0];
      cmd_word.fy = yc[FRAC_W-1:0];
    end else begin
      cmd_word.x0 = {1'b0, s3_cx_r};
      cmd_word.y0 = {1'b0, s3_cy_r};
      cmd_word.x1 = {1'b0, s3_cx_r};
      cmd_word.y1 = {1'b0, s3_cy_r};
      cmd_word.fx = '0;
      cmd_word.fy = '0;
    end
  end

  assign cmd_push = s3_v_r;

endmodule

// ----- src/bir_back.sv -----
// Back part: image memory, neighbour read sequencer and bilinear blend.
module bir_back
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  cmd_t                cmd_word,
  output logic                cmd_pop,
  input  logic [1:0]          nch,
  input  logic [OQ_LVL_W-1:0] out_level,
  output logic                res_push,
  output out_word_t           res_word
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  pix_t mem [2**AW];

  cmd_t        cur_r;
  logic        busy_r;
  logic [1:0]  phase_r;
  logic [2:0]  inflight_r;
  logic        credit_ok, start, start_req, mem_we, rd_en;
  logic [AW-1:0] addr;

  pix_t              rd_data_r, nb00_r, nb10_r, nb01_r;
  logic              rd_v_r;
  logic [1:0]        rd_tag_r;
  logic [FRAC_W-1:0] rd_fx_r, rd_fy_r, row_fx_r;
  logic              row_v_r;
  logic [2:0][15:0]  left_r, right_r, left_nxt, right_nxt;
  logic [2:0][15:0]  res;
  logic [8:0]        wy0, wy1, wx0, wx1;
  logic [23:0]       full_val;

  // Start a command when the sequencer is free; requests need room for their result.
  assign credit_ok = ({1'b0, out_level} + {1'b0, inflight_r}) < 4'(OQ_DEPTH);
  assign start     = !busy_r && !cmd_empty &&
                     ((cmd_word.kind == KIND_STORE) || credit_ok);
  assign start_req = start && (cmd_word.kind == KIND_REQUEST);
  assign cmd_pop   = start;
  assign mem_we    = start && (cmd_word.kind == KIND_STORE);
  assign rd_en     = start_req || busy_r;

  // Single port address: store, first neighbour, then the other three.
  always_comb begin
    if (!busy_r) begin
      addr = {YW'(cmd_word.y0), XW'(cmd_word.x0)};
    end else begin
      case (phase_r)
        2'd1:    addr = {YW'(cur_r.y1), XW'(cur_r.x0)};
        2'd2:    addr = {YW'(cur_r.y0), XW'(cur_r.x1)};
        2'd3:    addr = {YW'(cur_r.y1), XW'(cur_r.x1)};
        default: addr = {YW'(cur_r.y0), XW'(cur_r.x0)};
      endcase
    end
  end

  // Image memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cmd_word.pix;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Read sequencer and result credit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      phase_r    <= 2'd0;
      inflight_r <= 3'd0;
      rd_v_r     <= 1'b0;
      row_v_r    <= 1'b0;
    end else begin
      if (start_req) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd1;
      end else if (busy_r) begin
        phase_r <= phase_r + 1'b1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
      if (start_req && !res_push) begin
        inflight_r <= inflight_r + 1'b1;
      end else if (res_push && !start_req) begin
        inflight_r <= inflight_r - 1'b1;
      end
      rd_v_r  <= rd_en;
      row_v_r <= rd_v_r && (rd_tag_r == 2'd3);
    end
  end

  // Command and read tags.
  always_ff @(posedge clk) begin
    if (start_req) begin
      cur_r <= cmd_word;
    end
    rd_tag_r <= busy_r ? phase_r : 2'd0;
    rd_fx_r  <= cur_r.fx;
    rd_fy_r  <= cur_r.fy;
    row_fx_r <= rd_fx_r;
  end

  // Collect the first three neighbours; the fourth is used straight from the read.
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      case (rd_tag_r)
        2'd0:    nb00_r <= rd_data_r;
        2'd1:    nb10_r <= rd_data_r;
        2'd2:    nb01_r <= rd_data_r;
        default: nb01_r <= nb01_r;
      endcase
    end
  end

  // Row blend in Q8.8.
  assign wy1 = {1'b0, rd_fy_r};
  assign wy0 = 9'd256 - wy1;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      left_nxt[c]  = 16'({8'b0, nb00_r[c]} * {7'b0, wy0}) +
                     16'({8'b0, nb10_r[c]} * {7'b0, wy1});
      right_nxt[c] = 16'({8'b0, nb01_r[c]} * {7'b0, wy0}) +
                     16'({8'b0, rd_data_r[c]} * {7'b0, wy1});
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  // Column blend in Q8.16, rounded to Q8.8; absent channels read zero.
  assign wx1 = {1'b0, row_fx_r};
  assign wx0 = 9'd256 - wx1;
  always_comb begin
    full_val = '0;
    for (int c = 0; c < 3; c++) begin
      full_val = 24'({8'b0, left_r[c]} * {15'b0, wx0}) +
                 24'({8'b0, right_r[c]} * {15'b0, wx1}) + 24'd128;
      res[c] = (2'(c) < nch) ? full_val[23:8] : 16'd0;
    end
  end

  assign res_push        = row_v_r;
  assign res_word.out_c0 = res[0];
  assign res_word.out_c1 = res[1];
  assign res_word.out_c2 = res[2];

`ifndef SYNTHESIS
  // The single port never writes and reads in one cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en)) else $error("image memory write and read collide");

  // Results in flight never exceed the room in the result queue.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, out_level} + {1'b0, inflight_r}) <= 4'(OQ_DEPTH))
    else $error("result credit overrun");

  // A finished blend always finds room.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (out_level < OQ_LVL_W'(OQ_DEPTH))) else $error("result queue full");

  // Each request holds the sequencer for its four neighbour reads, so blends never come back to back.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    row_v_r |=> !row_v_r) else $error("blend results too close");
`endif

endmodule

// ----- src/bilinear_image_rescaler_top.sv -----
// Top level of the bilinear image rescaler: configuration registers and the two parts.
//
// The block behaves as a queue on both sides. A word is taken on a rising edge with
// push high and full low. A store word writes one pixel into the image memory; a
// request word names one output pixel of the OUT_WIDTH by OUT_HEIGHT grid. Words
// outside the memory or the grid are taken and dropped. Each request returns one
// result word, shown on out_word while empty is low and taken by pop.
// Stores are taken one per cycle while full is low. Each request holds the sequencer
// for its four neighbour reads from the single-port image memory, so the back starts
// no new command until those reads are done. A short command queue separates the
// mapping front from the memory back, and a four-word result queue lets the receiver
// stall; when it has no room left for further results, requests wait and full rises
// as queues fill. Configuration is written through cfg_we, cfg_idx and cfg_wdata; the
// user must do so only while idle, as the block itself does not enforce it. Reset
// clears the queues and restores width 256, height 256, three channels and vertical
// mirroring. Image memory content is undefined until written.
module bilinear_image_rescaler_top
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int OUT_WIDTH  = 256,
  parameter int OUT_HEIGHT = 256,
  parameter int CHANNELS   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  in_word_t              in_word,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam logic [1:0] CH_LIM = (CHANNELS > 3) ? 2'd3 : 2'(CHANNELS);

  logic [DIM_W-1:0]    src_width_r, src_height_r;
  logic [1:0]          src_ch_r, nch;
  logic                vflip_r;
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t                cmd_in, cmd_out;
  logic                res_push, oq_full;
  out_word_t           res_word;
  logic [OQ_LVL_W-1:0] out_level;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(256);
      src_height_r <= DIM_W'(256);
      src_ch_r     <= 2'd3;
      vflip_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SRC_WIDTH:    src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT:   src_height_r <= cfg_wdata;
        CFG_SRC_CHANNELS: src_ch_r     <= cfg_wdata[1:0];
        CFG_VFLIP:        vflip_r      <= cfg_wdata[0];
        default:          vflip_r      <= vflip_r;
      endcase
    end
  end

  // Channels present in the result.
  assign nch = (src_ch_r > CH_LIM) ? CH_LIM : src_ch_r;

  bir_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_word    (in_word),
    .full       (full),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .vflip      (vflip_r),
    .cmd_push   (cmd_push),
    .cmd_word   (cmd_in),
    .cmd_full   (cmd_full)
  );

  bir_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .level (cmd_level)
  );

  bir_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_out),
    .cmd_pop   (cmd_pop),
    .nch       (nch),
    .out_level (out_level),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  bir_fifo #(
    .W     ($bits(out_word_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (oq_full),
    .pop   (pop),
    .dout  (out_word),
    .empty (empty),
    .level (out_level)
  );

`ifndef SYNTHESIS
  // The command queue count stays within its depth.
  a_cmd_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_level <= ($bits(cmd_level))'(CMD_DEPTH)) else $error("command queue overrun");

  // Results never meet a full result queue.
  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full) else $error("result dropped");
`endif

endmodule

// ----- verif/bilinear_image_rescaler_top_test.sv -----
// Self-checking testbench for the bilinear image rescaler: random stores and requests, checked against a predictor.
module bilinear_image_rescaler_top_test
  import bir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SRC_MAX_W   = 512;
  localparam int unsigned SRC_MAX_H   = 512;
  localparam int unsigned GRID_W      = 256;
  localparam int unsigned GRID_H      = 256;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned COORD_TOP   = (1 << COORD_W) - 1;
  localparam int unsigned ITEM_TARGET = 600;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  in_word_t              in_word   = '0;
  logic                  full;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies, as the block holds them after reset.
  int unsigned cfg_width    = 256;
  int unsigned cfg_height   = 256;
  int unsigned cfg_channels = 3;
  bit          cfg_flip     = 1'b1;

  // Image contents as accepted, and entries that queued stores will have written.
  logic [23:0] image_mirror [int unsigned];
  bit          stored_plan  [int unsigned];

  in_word_t    pending_words[$];
  out_word_t   expected_pixels[$];
  int unsigned words_queued   = 0;
  int unsigned words_taken    = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  logic        in_fire        = 1'b0;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned hold_starts = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_seg   = 0;

  bilinear_image_rescaler_top #(
    .MAX_WIDTH (SRC_MAX_W),
    .MAX_HEIGHT(SRC_MAX_H),
    .OUT_WIDTH (GRID_W),
    .OUT_HEIGHT(GRID_H),
    .CHANNELS  (NUM_CH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Map one output coordinate to its two source neighbours and the Q.8 fraction.
  function automatic void axis_sample(input int unsigned coord, input int unsigned dim_reg,
                                      input int unsigned lim, input int unsigned grid,
                                      input bit mirror, output int unsigned lo,
                                      output int unsigned hi, output int unsigned frac);
    longint unsigned dim;
    longint unsigned pos;
    longint unsigned top;
    dim = (dim_reg == 0) ? 1 : ((dim_reg > lim) ? lim : dim_reg);
    pos = (longint'(coord) * dim * 256) / grid;
    if (mirror) begin
      pos = dim * 256 - pos;
    end
    top = (dim - 1) * 256;
    if (pos > top) begin
      pos = top;
    end
    lo   = int'(pos >> 8);
    frac = int'(pos & 255);
    hi   = (lo + 1 < dim) ? lo + 1 : lo;
  endfunction

  function automatic int unsigned pixel_channel(input int unsigned x, input int unsigned y,
                                                input int unsigned c);
    int unsigned idx;
    idx = y * SRC_MAX_W + x;
    if (image_mirror.exists(idx)) begin
      return (image_mirror[idx] >> (8 * c)) & 8'hFF;
    end
    return 0;
  endfunction

  // Bilinear blend of one requested output pixel; returns 0 when no result is due.
  function automatic bit predict_blend(input in_word_t w, output out_word_t r);
    int unsigned x0, x1, y0, y1, fx, fy, nch;
    int unsigned col_lo, col_hi, total;
    logic [2:0][15:0] chans;
    r = '0;
    if (w.coord_x >= GRID_W || w.coord_y >= GRID_H) begin
      return 1'b0;
    end
    axis_sample(w.coord_x, cfg_width, SRC_MAX_W, GRID_W, 1'b0, x0, x1, fx);
    axis_sample(w.coord_y, cfg_height, SRC_MAX_H, GRID_H, cfg_flip, y0, y1, fy);
    nch = cfg_channels;
    if (nch > NUM_CH) nch = NUM_CH;
    if (nch > 3) nch = 3;
    chans = '0;
    for (int c = 0; c < 3; c++) begin
      if (c < nch) begin
        // Rows first, then columns, then round back to Q8.8.
        col_lo = pixel_channel(x0, y0, c) * (256 - fy) + pixel_channel(x0, y1, c) * fy;
        col_hi = pixel_channel(x1, y0, c) * (256 - fy) + pixel_channel(x1, y1, c) * fy;
        total  = col_lo * (256 - fx) + col_hi * fx;
        chans[2 - c] = 16'((total + 128) >> 8);
      end
    end
    r = chans;
    return 1'b1;
  endfunction

  task automatic queue_store(input int unsigned x, input int unsigned y,
                             input logic [23:0] pix);
    in_word_t w;
    w.kind    = KIND_STORE;
    w.coord_x = COORD_W'(x);
    w.coord_y = COORD_W'(y);
    {w.sample_c2, w.sample_c1, w.sample_c0} = pix;
    stored_plan[y * SRC_MAX_W + x] = 1'b1;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic ensure_stored(input int unsigned x, input int unsigned y);
    if (!stored_plan.exists(y * SRC_MAX_W + x)) begin
      queue_store(x, y, 24'($urandom()));
    end
  endtask

  // A request inside the grid is preceded by stores of any neighbour not yet written.
  task automatic queue_request(input int unsigned cx, input int unsigned cy);
    in_word_t w;
    int unsigned x0, x1, y0, y1, fx, fy;
    if (cx < GRID_W && cy < GRID_H) begin
      axis_sample(cx, cfg_width, SRC_MAX_W, GRID_W, 1'b0, x0, x1, fx);
      axis_sample(cy, cfg_height, SRC_MAX_H, GRID_H, cfg_flip, y0, y1, fy);
      ensure_stored(x0, y0);
      ensure_stored(x1, y0);
      ensure_stored(x0, y1);
      ensure_stored(x1, y1);
    end
    w.kind    = KIND_REQUEST;
    w.coord_x = COORD_W'(cx);
    w.coord_y = COORD_W'(cy);
    {w.sample_c2, w.sample_c1, w.sample_c0} = 24'($urandom());
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:    cfg_width    = value & 10'h3FF;
      CFG_SRC_HEIGHT:   cfg_height   = value & 10'h3FF;
      CFG_SRC_CHANNELS: cfg_channels = value & 2'h3;
      CFG_VFLIP:        cfg_flip     = value[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned h,
                              input int unsigned ch, input int unsigned flip);
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
    write_reg(CFG_SRC_CHANNELS, ch);
    write_reg(CFG_VFLIP, flip);
  endtask

  // Wait until every queued word is taken and every result has come back.
  task automatic drain;
    while (words_taken != words_queued || expected_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !in_fire) begin
      // Word still waiting for the block, hold it.
    end else if (gap_left != 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (pending_words.size() != 0) begin
      in_word <= pending_words.pop_front();
      push    <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end else begin
      push <= 1'b0;
    end
  end

  // Receiver: segments of steady, random or sparse popping, plus the long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_seen != hold_starts) begin
      hold_seen = hold_starts;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_seg  = $urandom_range(10, 80);
      end
      stall_seg--;
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Predict on every accepted word and check every accepted result.
  always @(posedge clk) begin
    out_word_t        want;
    logic [2:0][15:0] want_ch;
    logic [2:0][15:0] got_ch;
    if (rst_n) begin
      in_fire <= push && !full;
      if (push && !full) begin
        words_taken++;
        if (in_word.kind == KIND_STORE) begin
          if (in_word.coord_x < SRC_MAX_W && in_word.coord_y < SRC_MAX_H) begin
            image_mirror[in_word.coord_y * SRC_MAX_W + in_word.coord_x] =
              {in_word.sample_c2, in_word.sample_c1, in_word.sample_c0};
          end
        end else if (predict_blend(in_word, want)) begin
          expected_pixels.push_back(want);
        end
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, out_word);
          mismatch_count++;
        end else begin
          want    = expected_pixels.pop_front();
          want_ch = want;
          got_ch  = out_word;
          for (int c = 0; c < 3; c++) begin
            if (got_ch[2 - c] !== want_ch[2 - c]) begin
              $display("%0t: out_c%0d expected %h, got %h", $time, c, want_ch[2 - c],
                       got_ch[2 - c]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moving either way.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus: one phase per register setting, directed corners first, then random words.
  initial begin
    int unsigned phase;
    int unsigned pick;
    phase = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (words_queued < ITEM_TARGET) begin
      case (phase)
        0: ;
        1: program_regs(0, 0, 0, 0);
        2: program_regs(1023, 1023, 3, 1);
        3: program_regs(512, 512, 1, 0);
        4: program_regs(1, 512, 2, 1);
        5: program_regs(513, 1, 3, 0);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            program_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 3), $urandom_range(0, 1));
          end else begin
            program_regs($urandom_range(1, 12), $urandom_range(1, 12),
                         $urandom_range(0, 3), $urandom_range(0, 1));
          end
        end
      endcase
      // Let the result queue back up while the sender keeps offering words.
      if (phase == 6) begin
        hold_starts++;
      end
      if (phase == 0) begin
        queue_store(COORD_TOP, COORD_TOP, 24'hFFFFFF);
        queue_store(0, 0, 24'h000000);
        queue_store(COORD_TOP, 0, 24'hFFFFFF);
        queue_store(0, COORD_TOP, 24'h000000);
        queue_request(GRID_W, 0);
        queue_request(COORD_TOP, COORD_TOP);
      end
      // Corners of the output grid: flipped top edge and right/bottom borders.
      queue_request(0, 0);
      queue_request(GRID_W - 1, GRID_H - 1);
      queue_request(GRID_W - 1, 0);
      queue_request(0, GRID_H - 1);
      repeat ((phase < 6) ? 20 : 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          queue_request($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
        end else if (pick < 75) begin
          queue_request($urandom_range(0, 1) ? GRID_W - 1 : $urandom_range(0, 3),
                        $urandom_range(0, 1) ? GRID_H - 1 : $urandom_range(0, 3));
        end else if (pick < 85) begin
          if ($urandom_range(0, 1)) begin
            queue_request($urandom_range(GRID_W, COORD_TOP), $urandom_range(0, COORD_TOP));
          end else begin
            queue_request($urandom_range(0, COORD_TOP), $urandom_range(GRID_H, COORD_TOP));
          end
        end else begin
          queue_store($urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
                      24'($urandom()));
        end
      end
      drain();
      repeat (SETTLE) @(negedge clk);
      phase++;
    end
    drain();
    repeat (SETTLE) @(negedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
